>>> rtl/core/spq_pkg.sv
// Package for the sorted priority queue: payload structs, cell types and codes.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

   localparam int unsigned DEFAULT_DEPTH = 16;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned RANK_W = 16;
   localparam int unsigned COUNT_W = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_DELETED = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic                      op;
      logic signed [VALUE_W-1:0] entry_value;
      logic signed [RANK_W-1:0]  entry_rank;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                status;
      logic signed [VALUE_W-1:0] out_value;
      logic signed [RANK_W-1:0]  out_rank;
      logic [COUNT_W-1:0]        count;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [RANK_W-1:0]  rank;
   } entry_type;

   typedef struct packed {
      logic      do_insert;
      logic      do_delete;
      entry_type entry;
   } cell_cmd_type;

endpackage

>>> rtl/core/spq_cell.sv
// One slot of the sorted row: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and command types.
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         occupied,
   input  logic         left_le,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output logic         le,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   assign le = occupied && (entry_ff.rank <= cmd.entry.rank);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.do_insert) begin
         if (!le) begin
            entry_in = left_le ? cmd.entry : left_entry;
         end
      end else if (cmd.do_delete) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue, lowest rank served first, equal ranks in arrival order.
// Depends on spq_pkg and spq_cell.
//
// The queue takes one insert or delete transaction per clock cycle and returns its result in
// the following cycle from an output register; a new transaction is taken whenever that
// register is empty or being drained. The entries sit in a row of DEPTH cells, and every cell
// compares its rank with the incoming one in the same cycle and shifts toward or away from the
// front with its neighbor, so the compare-and-shift across the whole row sets the rate.
// An insert into a full queue and a delete from an empty queue report their status and leave
// the contents untouched. The count field gives the low five bits of the resulting count.
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_payload_type  rsp_payload_ff;
   rsp_payload_type  rsp_payload_in;

   logic               accept;
   logic               is_full;
   logic               is_empty;
   cell_cmd_type       cmd;
   logic [DEPTH-1:0]   le;
   entry_type          entry [DEPTH];
   logic [CNT_W+4:0]   cnt_ext;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign is_full = (cnt_ff == CNT_W'(DEPTH));
   assign is_empty = (cnt_ff == '0);

   assign cmd.do_insert = accept && (req_payload.op == OP_INSERT) && !is_full;
   assign cmd.do_delete = accept && (req_payload.op == OP_DELETE) && !is_empty;
   assign cmd.entry.value = req_payload.entry_value;
   assign cmd.entry.rank = req_payload.entry_rank;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CNT_W'(i) < cnt_ff),
         .left_le     ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i - 1]),
         .left_entry  (entry[(i == 0) ? 0 : i - 1]),
         .right_entry (entry[(i == DEPTH - 1) ? i : i + 1]),
         .le          (le[i]),
         .entry       (entry[i])
      );
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.do_insert) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.do_delete) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      cnt_ext = {5'b0, cnt_in};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.out_value = '0;
         rsp_payload_in.out_rank = '0;
         rsp_payload_in.count = cnt_ext[4:0];
         unique case (req_payload.op)
            OP_INSERT: begin
               rsp_payload_in.status = is_full ? ST_FULL : ST_INSERTED;
            end
            OP_DELETE: begin
               if (is_empty) begin
                  rsp_payload_in.status = ST_EMPTY;
               end else begin
                  rsp_payload_in.status = ST_DELETED;
                  rsp_payload_in.out_value = entry[0].value;
                  rsp_payload_in.out_rank = entry[0].rank;
               end
            end
            default: begin
               rsp_payload_in.status = ST_EMPTY;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("Entry count exceeds the queue depth.");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("Accepted transaction produced no response.");

   a_full_holds_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.op == OP_INSERT && is_full) |=> (cnt_ff == CNT_W'(DEPTH)))
      else $error("Insert into a full queue changed the count.");

   a_empty_holds_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.op == OP_DELETE && is_empty) |=> (cnt_ff == '0))
      else $error("Delete from an empty queue changed the count.");
`endif

endmodule

>>> bench/sorted_priority_queue_test.sv
// Self-checking testbench for sorted_priority_queue: a directed empty delete, fill, overflow
// and partial drain, then random insert/delete traffic, checked against an in-bench
// sorted-list predictor. Depends on spq_pkg and the sorted_priority_queue RTL.
module sorted_priority_queue_test
   import spq_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_PER_PHASE = 350;

   typedef struct {
      req_payload_type payload;
      bit              drain_first;
      int unsigned     send_idle_pct;
      int unsigned     rsp_stall_pct;
   } pending_item_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   pending_item_type pending_items[$];
   rsp_payload_type  expected_results[$];
   pending_item_type next_item;

   entry_type   held_entries[DEFAULT_DEPTH];
   int unsigned held_count = 0;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   bit          req_taken = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned failure_count = 0;
   int unsigned checked_count = 0;
   int unsigned insert_count = 0;
   int unsigned delete_count = 0;
   int unsigned full_reject_count = 0;
   int unsigned empty_delete_count = 0;

   sorted_priority_queue #(.DEPTH(DEFAULT_DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one transaction to the sorted list and returns the result it must produce.
   function automatic rsp_payload_type apply_to_queue(req_payload_type req);
      rsp_payload_type outcome;
      int unsigned     slot;
      outcome = '0;
      if (req.op == OP_INSERT) begin
         if (held_count >= DEFAULT_DEPTH) begin
            outcome.status = ST_FULL;
            full_reject_count++;
         end else begin
            slot = 0;
            while (slot < held_count && held_entries[slot].rank <= req.entry_rank) begin
               slot++;
            end
            for (int unsigned i = held_count; i > slot; i--) begin
               held_entries[i] = held_entries[i-1];
            end
            held_entries[slot].value = req.entry_value;
            held_entries[slot].rank = req.entry_rank;
            held_count++;
            outcome.status = ST_INSERTED;
            insert_count++;
         end
      end else begin
         if (held_count == 0) begin
            outcome.status = ST_EMPTY;
            empty_delete_count++;
         end else begin
            outcome.out_value = held_entries[0].value;
            outcome.out_rank = held_entries[0].rank;
            for (int unsigned i = 1; i < held_count; i++) begin
               held_entries[i-1] = held_entries[i];
            end
            held_count--;
            outcome.status = ST_DELETED;
            delete_count++;
         end
      end
      outcome.count = COUNT_W'(held_count);
      return outcome;
   endfunction

   task automatic queue_request(logic op, logic signed [VALUE_W-1:0] value,
                                logic signed [RANK_W-1:0] rank, bit drain_first,
                                int unsigned idle_pct, int unsigned stall_pct);
      pending_item_type item;
      item.payload.op = op;
      item.payload.entry_value = value;
      item.payload.entry_rank = rank;
      item.drain_first = drain_first;
      item.send_idle_pct = idle_pct;
      item.rsp_stall_pct = stall_pct;
      pending_items.push_back(item);
   endtask

   function automatic logic signed [RANK_W-1:0] pick_rank();
      logic signed [RANK_W-1:0] rank;
      case ($urandom_range(3))
         0: begin
            rank = RANK_W'($urandom_range(7));
         end
         1: begin
            case ($urandom_range(3))
               0: rank = 16'sh8000;
               1: rank = 16'sh7fff;
               2: rank = -16'sd1;
               default: rank = 16'sd0;
            endcase
         end
         default: begin
            rank = RANK_W'($urandom);
         end
      endcase
      return rank;
   endfunction

   // Random traffic in runs whose insert share swings, so the queue often fills and empties.
   task automatic queue_random_phase(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall_pct);
      int unsigned insert_pct;
      logic        op;
      insert_pct = 50;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: insert_pct = 25;
               1: insert_pct = 50;
               default: insert_pct = 75;
            endcase
         end
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
         queue_request(op, VALUE_W'($urandom), pick_rank(), i == 0, idle_pct, stall_pct);
      end
   endtask

   task automatic queue_directed();
      queue_request(OP_DELETE, 32'sh7fffffff, 16'sh7fff, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sh7fffffff, 16'sh7fff, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sh80000000, 16'sh8000, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd0, 16'sd0, 1'b0, 0, 0);
      queue_request(OP_INSERT, -32'sd1, -16'sd1, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd1, 16'sd5, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd2, 16'sd5, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd3, 16'sd5, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sh55555555, 16'sh5555, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'shaaaaaaaa, 16'shaaaa, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd4, 16'sh8000, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd5, 16'sh7fff, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd6, 16'sd0, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd7, 16'sd1, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd8, -16'sd2, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd9, 16'sd5, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd10, 16'sd100, 1'b0, 0, 0);
      queue_request(OP_INSERT, 32'sd11, 16'sd0, 1'b0, 0, 0);
      for (int unsigned i = 0; i < 7; i++) begin
         queue_request(OP_DELETE, VALUE_W'($urandom), RANK_W'($urandom), 1'b0, 0, 0);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_items.size() != 0
                && !(pending_items[0].drain_first && expected_results.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_payload <= next_item.payload;
               send_idle_pct <= next_item.send_idle_pct;
               rsp_stall_pct <= next_item.rsp_stall_pct;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_payload_type expected;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            expected_results.push_back(apply_to_queue(req_payload));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no request waiting: %p", rsp_payload);
               failure_count++;
            end else begin
               expected = expected_results.pop_front();
               checked_count++;
               if (rsp_payload.status !== expected.status) begin
                  $error("status: expected %0d, actual %0d", expected.status, rsp_payload.status);
                  failure_count++;
               end
               if (rsp_payload.out_value !== expected.out_value) begin
                  $error("out_value: expected %0d, actual %0d",
                         expected.out_value, rsp_payload.out_value);
                  failure_count++;
               end
               if (rsp_payload.out_rank !== expected.out_rank) begin
                  $error("out_rank: expected %0d, actual %0d",
                         expected.out_rank, rsp_payload.out_rank);
                  failure_count++;
               end
               if (rsp_payload.count !== expected.count) begin
                  $error("count: expected %0d, actual %0d", expected.count, rsp_payload.count);
                  failure_count++;
               end
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("** sorted_priority_queue: FAILED **");
      $finish;
   end

   initial begin
      queue_directed();
      queue_random_phase(RANDOM_PER_PHASE, 0, 0);
      queue_random_phase(RANDOM_PER_PHASE, 47, 0);
      queue_random_phase(RANDOM_PER_PHASE, 0, 47);
      queue_random_phase(RANDOM_PER_PHASE, 17, 17);
      queue_random_phase(RANDOM_PER_PHASE, 0, 0);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_items.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      $display("Checked %0d results: %0d inserts, %0d deletes, %0d full rejects,",
               checked_count, insert_count, delete_count, full_reject_count);
      $display("and %0d empty deletes.", empty_delete_count);
      $display("Traffic ran with no idling, sender gaps, receiver stalls and both combined.");
      if (failure_count == 0) begin
         $display("** sorted_priority_queue: PASSED **");
      end else begin
         $display("** sorted_priority_queue: FAILED **");
      end
      $finish;
   end

endmodule
